[sv/utfdec_pkg.sv]
// utfdec_pkg: types, codes and constants for the utf-8 / utf-16 stream decoder
// no dependencies; used by utf8_utf16_stream_decoder_core
`default_nettype none

package utfdec_pkg;

    // text mode register codes
    typedef enum logic [1:0] {
        MODE_ASCII    = 2'd0,
        MODE_UTF8     = 2'd1,
        MODE_UTF16_LE = 2'd2,
        MODE_UTF16_BE = 2'd3
    } text_mode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_CHAR      = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned PEND_W   = 2;

    // stream data widths, packed to whole bytes
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;

    // configuration port
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;
    localparam logic [1:0]  REG_TEXT_MODE = 2'd0;

    // surrogate and continuation constants
    localparam logic [UNIT_W-1:0] SURR_MASK   = 16'hfc00;
    localparam logic [UNIT_W-1:0] SURR_HIGH   = 16'hd800;
    localparam logic [UNIT_W-1:0] SURR_LOW    = 16'hdc00;
    localparam logic [CP_W-1:0]   SUPP_OFFSET = 21'h10000;
    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hc0;
    localparam logic [BYTE_W-1:0] CONT_VALUE  = 8'h80;

endpackage

`default_nettype wire

[sv/utf8_utf16_stream_decoder_core.sv]
// utf8_utf16_stream_decoder_core: byte stream in, code points out
// depends on utfdec_pkg
`default_nettype none

// One raw byte is taken per transfer on the slave side; tlast marks end of
// stream (the byte is then ignored). A finished character, a malformed
// sequence report or a truncation report leaves on the master side as one
// transfer: code point in tdata[20:0], status in tdata[22:21]. The block
// takes one byte every cycle unless the master side stalls: each byte
// passes an input register, one level of decode logic against the small
// accumulator state, and a result register before its result leaves.
// Bytes that only extend a sequence give no result. Writing text_mode (byte
// address 0) clears all decode state; write it only while the stream is idle.
// Reset selects UTF-8.
module utf8_utf16_stream_decoder_core
(
    input  wire                                clk,
    input  wire                                rst_n,

    // byte stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [utfdec_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  wire                                s_tlast,   // end_of_stream

    // code point stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [utfdec_pkg::M_TDATA_W-1:0]   m_tdata,   // [20:0] code_point,
                                                          // [22:21] status, [23] zero

    // configuration
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [utfdec_pkg::PADDR_W-1:0]     paddr,
    input  wire  [utfdec_pkg::PDATA_W-1:0]     pwdata,
    output logic [utfdec_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready
);

    // configuration register
    utfdec_pkg::text_mode_t                    mode_reg;
    logic                                      cfg_write;

    // input register
    logic                                      in_valid_reg;
    logic [utfdec_pkg::BYTE_W-1:0]             in_byte_reg;
    logic                                      in_last_reg;

    // decode state
    logic [utfdec_pkg::CP_W-1:0]               partial_reg, partial_next;
    logic [utfdec_pkg::PEND_W-1:0]             pending_reg, pending_next;
    logic                                      phase_reg, phase_next;
    logic [utfdec_pkg::BYTE_W-1:0]             held_reg, held_next;
    logic                                      surr_reg, surr_next;

    // result register
    logic                                      out_valid_reg, out_valid_next;
    logic [utfdec_pkg::CP_W-1:0]               out_cp_reg;
    utfdec_pkg::status_t                       out_status_reg;

    // decode results
    logic                                      advance;
    logic                                      emit;
    logic [utfdec_pkg::CP_W-1:0]               emit_cp;
    utfdec_pkg::status_t                       emit_status;
    logic [utfdec_pkg::UNIT_W-1:0]             unit;
    logic [utfdec_pkg::CP_W-1:0]               shifted;

    // handshake control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[utfdec_pkg::PADDR_W-1:2] == utfdec_pkg::REG_TEXT_MODE);
    assign prdata    = (paddr[utfdec_pkg::PADDR_W-1:2] == utfdec_pkg::REG_TEXT_MODE)
                       ? {{(utfdec_pkg::PDATA_W-2){1'b0}}, mode_reg}
                       : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= utfdec_pkg::MODE_UTF8;
        end
        else if (cfg_write)
        begin
            mode_reg <= utfdec_pkg::text_mode_t'(pwdata[1:0]);
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata[utfdec_pkg::BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    // utf-16 unit in the selected byte order, utf-8 accumulator shift
    assign unit = (mode_reg == utfdec_pkg::MODE_UTF16_BE) ? {held_reg, in_byte_reg}
                                                          : {in_byte_reg, held_reg};
    assign shifted = {partial_reg[utfdec_pkg::CP_W-7:0], in_byte_reg[5:0]};

    // decode of one byte against the current state
    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        phase_next   = phase_reg;
        held_next    = held_reg;
        surr_next    = surr_reg;
        emit         = 1'b0;
        emit_cp      = '0;
        emit_status  = utfdec_pkg::ST_CHAR;

        if (in_last_reg)
        begin
            // end of stream: report any partial sequence
            partial_next = '0;
            pending_next = '0;
            phase_next   = 1'b0;
            held_next    = '0;
            surr_next    = 1'b0;
            if ((pending_reg != '0) || phase_reg || surr_reg)
            begin
                emit        = 1'b1;
                emit_status = utfdec_pkg::ST_TRUNCATED;
            end
        end
        else
        begin
            case (mode_reg)
                utfdec_pkg::MODE_ASCII:
                begin
                    emit    = 1'b1;
                    emit_cp = {{(utfdec_pkg::CP_W-utfdec_pkg::BYTE_W){1'b0}}, in_byte_reg};
                end
                utfdec_pkg::MODE_UTF8:
                begin
                    if (pending_reg != '0)
                    begin
                        if ((in_byte_reg & utfdec_pkg::CONT_MASK) != utfdec_pkg::CONT_VALUE)
                        begin
                            // bad continuation drops the whole sequence
                            partial_next = '0;
                            pending_next = '0;
                            emit         = 1'b1;
                            emit_status  = utfdec_pkg::ST_MALFORMED;
                        end
                        else if (pending_reg == 2'd1)
                        begin
                            partial_next = '0;
                            pending_next = '0;
                            emit         = 1'b1;
                            emit_cp      = shifted;
                        end
                        else
                        begin
                            partial_next = shifted;
                            pending_next = pending_reg - 2'd1;
                        end
                    end
                    else if (!in_byte_reg[7])
                    begin
                        emit    = 1'b1;
                        emit_cp = {{(utfdec_pkg::CP_W-utfdec_pkg::BYTE_W){1'b0}}, in_byte_reg};
                    end
                    else if (in_byte_reg[7:5] == 3'b110)
                    begin
                        partial_next = {{(utfdec_pkg::CP_W-5){1'b0}}, in_byte_reg[4:0]};
                        pending_next = 2'd1;
                    end
                    else if (in_byte_reg[7:4] == 4'b1110)
                    begin
                        partial_next = {{(utfdec_pkg::CP_W-4){1'b0}}, in_byte_reg[3:0]};
                        pending_next = 2'd2;
                    end
                    else if (in_byte_reg[7:3] == 5'b11110)
                    begin
                        partial_next = {{(utfdec_pkg::CP_W-3){1'b0}}, in_byte_reg[2:0]};
                        pending_next = 2'd3;
                    end
                    else
                    begin
                        // stray continuation or five-plus leading ones
                        emit        = 1'b1;
                        emit_status = utfdec_pkg::ST_MALFORMED;
                    end
                end
                default:
                begin
                    // utf-16, either byte order
                    if (!phase_reg)
                    begin
                        held_next  = in_byte_reg;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        held_next  = '0;
                        if (surr_reg)
                        begin
                            surr_next    = 1'b0;
                            partial_next = '0;
                            emit         = 1'b1;
                            if ((unit & utfdec_pkg::SURR_MASK) != utfdec_pkg::SURR_LOW)
                            begin
                                emit_status = utfdec_pkg::ST_MALFORMED;
                            end
                            else
                            begin
                                emit_cp = utfdec_pkg::SUPP_OFFSET
                                          + {1'b0, partial_reg[9:0], unit[9:0]};
                            end
                        end
                        else if ((unit & utfdec_pkg::SURR_MASK) == utfdec_pkg::SURR_HIGH)
                        begin
                            partial_next = {{(utfdec_pkg::CP_W-10){1'b0}}, unit[9:0]};
                            surr_next    = 1'b1;
                        end
                        else
                        begin
                            emit    = 1'b1;
                            emit_cp = {{(utfdec_pkg::CP_W-utfdec_pkg::UNIT_W){1'b0}}, unit};
                        end
                    end
                end
            endcase
        end
    end

    // decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= '0;
            phase_reg   <= 1'b0;
            held_reg    <= '0;
            surr_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            partial_reg <= '0;
            pending_reg <= '0;
            phase_reg   <= 1'b0;
            held_reg    <= '0;
            surr_reg    <= 1'b0;
        end
        else if (advance)
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            surr_reg    <= surr_next;
        end
    end

    // result register
    always_comb
    begin
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_cp_reg     <= emit_cp;
            out_status_reg <= emit_status;
        end
    end

    // master side transfer
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_status_reg, out_cp_reg};

endmodule

`default_nettype wire
